// ===== sv/ffpa_pkg.sv =====
// Package for the first-fit pool allocator: field widths, state and status codes,
// and the controller/datapath command and status structs. No dependencies.
`default_nettype none

package ffpa_pkg;

  localparam int REQ_W  = 12;
  localparam int OFF_W  = 12;
  localparam int FREE_W = 13;
  localparam int STAT_W = 2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFIT  = 2'd1,
    STAT_BADREL = 2'd2
  } stat_t;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EV, S_ALLOC, S_UP, S_UPW, S_WREM, S_WCUR,
    S_RDN, S_EVN, S_MRG, S_DN, S_DNW, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    RS_IDX, RS_NEXT, RS_UP, RS_DN
  } rsel_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_UP, WR_DN, WR_REM, WR_SPLIT, WR_WHOLE, WR_MERGE
  } wop_t;

  typedef struct packed {
    logic  take;
    logic  rd;
    rsel_t rsel;
    wop_t  wop;
    logic  idx_inc;
    logic  keep_prev;
    logic  keep_cur;
    logic  keep_nxt;
    logic  up_init;
    logic  dn_done;
    logic  set_stat;
    stat_t stat;
    logic  load_out;
  } ffpa_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic scan_end;
    logic hit;
    logic match;
    logic e_free;
    logic has_next;
    logic split;
    logic up_more;
    logic dn_more;
    logic out_busy;
  } ffpa_stat_t;

endpackage

`default_nettype wire

// ===== sv/ffpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffpa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [$clog2(D)-1:0] wr_addr,
  input  wire logic [W-1:0]         wr_data,
  input  wire logic                 rd_en,
  input  wire logic [$clog2(D)-1:0] rd_addr,
  output logic      [W-1:0]         rd_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ffpa_ctrl.sv =====
// Controller FSM of the pool allocator: sequences scan, shift and merge steps.
// Depends on ffpa_pkg.
`default_nettype none

module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire ffpa_stat_t st,
  output ffpa_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rsel  = RS_IDX;
    cmd.wop   = WR_NONE;
    cmd.stat  = STAT_OK;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (st.scan_end) begin
          cmd.set_stat = 1'b1;
          cmd.stat     = st.is_alloc ? STAT_NOFIT : STAT_BADREL;
          state_nxt    = S_FIN;
        end else begin
          cmd.rd    = 1'b1;
          cmd.rsel  = RS_IDX;
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        if (st.is_alloc) begin
          if (st.hit) begin
            cmd.keep_cur = 1'b1;
            state_nxt    = S_ALLOC;
          end else begin
            cmd.keep_prev = 1'b1;
            cmd.idx_inc   = 1'b1;
            state_nxt     = S_RD;
          end
        end else if (st.match) begin
          if (st.e_free) begin
            cmd.set_stat = 1'b1;
            cmd.stat     = STAT_BADREL;
            state_nxt    = S_FIN;
          end else begin
            cmd.keep_cur = 1'b1;
            state_nxt    = st.has_next ? S_RDN : S_MRG;
          end
        end else begin
          cmd.keep_prev = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_ALLOC: begin
        if (st.split) begin
          cmd.up_init = 1'b1;
          state_nxt   = S_UP;
        end else begin
          cmd.wop      = WR_WHOLE;
          cmd.set_stat = 1'b1;
          cmd.stat     = STAT_OK;
          state_nxt    = S_FIN;
        end
      end
      S_UP: begin
        if (st.up_more) begin
          cmd.rd    = 1'b1;
          cmd.rsel  = RS_UP;
          state_nxt = S_UPW;
        end else begin
          state_nxt = S_WREM;
        end
      end
      S_UPW: begin
        cmd.wop   = WR_UP;
        state_nxt = S_UP;
      end
      S_WREM: begin
        cmd.wop   = WR_REM;
        state_nxt = S_WCUR;
      end
      S_WCUR: begin
        cmd.wop      = WR_SPLIT;
        cmd.set_stat = 1'b1;
        cmd.stat     = STAT_OK;
        state_nxt    = S_FIN;
      end
      S_RDN: begin
        cmd.rd    = 1'b1;
        cmd.rsel  = RS_NEXT;
        state_nxt = S_EVN;
      end
      S_EVN: begin
        cmd.keep_nxt = 1'b1;
        state_nxt    = S_MRG;
      end
      S_MRG: begin
        cmd.wop   = WR_MERGE;
        state_nxt = S_DN;
      end
      S_DN: begin
        if (st.dn_more) begin
          cmd.rd    = 1'b1;
          cmd.rsel  = RS_DN;
          state_nxt = S_DNW;
        end else begin
          cmd.dn_done  = 1'b1;
          cmd.set_stat = 1'b1;
          cmd.stat     = STAT_OK;
          state_nxt    = S_FIN;
        end
      end
      S_DNW: begin
        cmd.wop   = WR_DN;
        state_nxt = S_DN;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ffpa_dp.sv =====
// Datapath of the pool allocator: segment table RAM, scan index, counts,
// merge/split arithmetic and the result register. Depends on ffpa_pkg, ffpa_ram.
`default_nettype none

module ffpa_dp
  import ffpa_pkg::*;
#(
  parameter int POOL_BYTES   = 4096,
  parameter int HDR_BYTES    = 16,
  parameter int MAX_SEGMENTS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_command,
  input  wire logic [REQ_W-1:0]  in_req_size,
  input  wire logic [OFF_W-1:0]  in_release_offset,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [STAT_W-1:0] out_status,
  output logic      [OFF_W-1:0]  out_data_offset,
  output logic      [FREE_W-1:0] out_free_bytes,
  input  wire ffpa_cmd_t         cmd,
  output ffpa_stat_t             st
);

  localparam int SW = $clog2(POOL_BYTES);
  localparam int LW = SW + 1;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = IW + 1;
  localparam int AW = ((LW > FREE_W) ? LW : FREE_W) + 1;
  localparam int EW = 1 + LW + SW;
  localparam logic [AW-1:0] HDR_A  = AW'(HDR_BYTES);
  localparam logic [AW-1:0] OFF_MAX = AW'((1 << OFF_W) - 1);
  localparam logic [EW-1:0] ENT0_RST = {1'b1, LW'(POOL_BYTES - HDR_BYTES), SW'(0)};

  // table word: {free, data length, header offset}
  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, ram_q, rd_q;
  logic          rd0_r, e0w_r;

  op_t               cmd_r;
  logic [REQ_W-1:0]  req_r;
  logic [OFF_W-1:0]  roff_r;
  logic [CW-1:0]     idx_r, cnt_r, sh_r;
  logic [1:0]        rm_r;
  logic [LW-1:0]     free_r;
  logic [EW-1:0]     cur_r, prev_r, nxt_r;
  stat_t             stat_r;
  logic [OFF_W-1:0]  doff_r;

  logic              r_free;
  logic [LW-1:0]     r_len;
  logic [SW-1:0]     r_start;
  logic              p_free, n_free;
  logic [LW-1:0]     c_len, p_len, n_len;
  logic [SW-1:0]     c_start, p_start;
  logic [AW-1:0]     r_dsum, c_dsum, rest;
  logic [AW-1:0]     free_ext;
  logic              nf, pf;
  logic [1:0]        mr;
  logic [AW-1:0]     mlen;
  logic [CW-1:0]     mt;

  ffpa_ram #(.W(EW), .D(MAX_SEGMENTS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // entry 0 reads as the reset segment until first written
  assign rd_q = (rd0_r && !e0w_r) ? ENT0_RST : ram_q;
  assign {r_free, r_len, r_start} = rd_q;
  assign c_len   = cur_r[LW+SW-1:SW];
  assign c_start = cur_r[SW-1:0];
  assign {p_free, p_len, p_start} = prev_r;
  assign n_free  = nxt_r[EW-1];
  assign n_len   = nxt_r[LW+SW-1:SW];

  assign r_dsum = AW'(r_start) + HDR_A;
  assign c_dsum = AW'(c_start) + HDR_A;
  assign rest   = AW'(c_len) - AW'(req_r);

  assign nf   = ((idx_r + CW'(1)) < cnt_r) && n_free;
  assign pf   = (idx_r != '0) && p_free;
  assign mr   = {1'b0, nf} + {1'b0, pf};
  assign mlen = AW'(c_len) + (nf ? AW'(n_len) + HDR_A : '0)
                           + (pf ? AW'(p_len) + HDR_A : '0);
  assign mt   = pf ? idx_r - CW'(1) : idx_r;

  always_comb begin
    unique case (cmd.rsel)
      RS_IDX:  rd_addr = idx_r[IW-1:0];
      RS_NEXT: rd_addr = IW'(idx_r + CW'(1));
      RS_UP:   rd_addr = IW'(sh_r - CW'(1));
      RS_DN:   rd_addr = IW'(sh_r + CW'(rm_r));
      default: rd_addr = idx_r[IW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_r[IW-1:0];
    wr_data = rd_q;
    unique case (cmd.wop)
      WR_NONE:  wr_en = 1'b0;
      WR_UP:    wr_addr = sh_r[IW-1:0];
      WR_DN:    wr_addr = sh_r[IW-1:0];
      WR_REM: begin
        wr_addr = IW'(idx_r + CW'(1));
        wr_data = {1'b1, LW'(rest - HDR_A), SW'(c_dsum + AW'(req_r))};
      end
      WR_SPLIT: wr_data = {1'b0, LW'(req_r), c_start};
      WR_WHOLE: wr_data = {1'b0, c_len, c_start};
      WR_MERGE: begin
        wr_addr = mt[IW-1:0];
        wr_data = {1'b1, LW'(mlen), pf ? p_start : c_start};
      end
      default:  wr_en = 1'b0;
    endcase
  end

  always_comb begin
    st.is_alloc = (cmd_r == CMD_ALLOC);
    st.scan_end = (idx_r >= cnt_r);
    st.hit      = r_free && (AW'(r_len) >= AW'(req_r));
    st.match    = (r_dsum[OFF_W-1:0] == roff_r) && (r_dsum <= OFF_MAX);
    st.e_free   = r_free;
    st.has_next = (idx_r + CW'(1)) < cnt_r;
    st.split    = (rest >= HDR_A) && (cnt_r < CW'(MAX_SEGMENTS));
    st.up_more  = sh_r > (idx_r + CW'(1));
    st.dn_more  = (rm_r != 2'd0) && ((sh_r + CW'(rm_r)) < cnt_r);
    st.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0w_r     <= 1'b0;
      rd0_r     <= 1'b0;
      cnt_r     <= CW'(1);
      free_r    <= LW'(POOL_BYTES - HDR_BYTES);
      idx_r     <= '0;
      sh_r      <= '0;
      rm_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.rd) begin
        rd0_r <= (rd_addr == '0);
      end
      if (wr_en && wr_addr == '0) begin
        e0w_r <= 1'b1;
      end
      if (cmd.take) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.up_init) begin
        sh_r <= cnt_r;
      end
      unique case (cmd.wop)
        WR_UP:    sh_r <= sh_r - CW'(1);
        WR_DN:    sh_r <= sh_r + CW'(1);
        WR_SPLIT: begin
          cnt_r  <= cnt_r + CW'(1);
          free_r <= LW'(AW'(free_r) - HDR_A - AW'(req_r));
        end
        WR_WHOLE: free_r <= free_r - c_len;
        WR_MERGE: begin
          free_r <= LW'(AW'(free_r) + AW'(c_len) + (nf ? HDR_A : '0) + (pf ? HDR_A : '0));
          sh_r   <= mt + CW'(1);
          rm_r   <= mr;
        end
        default: ;
      endcase
      if (cmd.dn_done) begin
        cnt_r <= cnt_r - CW'(rm_r);
        rm_r  <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign free_ext = AW'(free_r);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cmd_r  <= op_t'(in_command);
      req_r  <= in_req_size;
      roff_r <= in_release_offset;
      doff_r <= '0;
    end else if (cmd.wop == WR_SPLIT || cmd.wop == WR_WHOLE) begin
      doff_r <= c_dsum[OFF_W-1:0];
    end
    if (cmd.keep_cur)  cur_r  <= rd_q;
    if (cmd.keep_prev) prev_r <= rd_q;
    if (cmd.keep_nxt)  nxt_r  <= rd_q;
    if (cmd.set_stat)  stat_r <= cmd.stat;
    if (cmd.load_out) begin
      out_status      <= stat_r;
      out_data_offset <= doff_r;
      out_free_bytes  <= free_ext[FREE_W-1:0];
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 && cnt_r <= CW'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= LW'(POOL_BYTES - HDR_BYTES))
    else $error("free count above pool size");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && cmd.rd))
    else $error("table read and write in one cycle");

  a_fail_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out && stat_r != STAT_OK |=> out_data_offset == '0)
    else $error("failed word carries an offset");

endmodule

`default_nettype wire

// ===== sv/first_fit_pool_allocator.sv =====
// First-fit pool allocator with coalescing: top level joining controller and datapath.
// Depends on ffpa_pkg, ffpa_ctrl, ffpa_dp (and ffpa_ram below it).
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one word: in_command (0 allocate,
//    1 release), in_req_size, in_release_offset.
//  - Output channel (out_valid/out_ready) returns one word per input word:
//    out_status, out_data_offset, out_free_bytes.
//  - One word is processed at a time. The segment table sits in a single-port-
//    read RAM; the scan reads and checks one segment after another. A split
//    shifts the later entries up by one, reading and writing each; a release
//    with merging shifts the later entries down by the number of merged neighbours.
//  - The result sits in an output register; a new word is taken as soon as
//    the controller is idle, even while the last result waits. A stalled
//    receiver holds a finished word in the last step until the output frees.
//  - Reset (rst_n low, synchronous) leaves one free segment covering the pool
//    less one header; no clearing pass is needed.
`default_nettype none

module first_fit_pool_allocator
  import ffpa_pkg::*;
#(
  parameter int POOL_BYTES   = 4096,
  parameter int HDR_BYTES    = 16,
  parameter int MAX_SEGMENTS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_command,
  input  wire logic [REQ_W-1:0]  in_req_size,
  input  wire logic [OFF_W-1:0]  in_release_offset,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [STAT_W-1:0] out_status,
  output logic      [OFF_W-1:0]  out_data_offset,
  output logic      [FREE_W-1:0] out_free_bytes
);

  ffpa_cmd_t  cmd;
  ffpa_stat_t st;

  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ffpa_dp #(
    .POOL_BYTES   (POOL_BYTES),
    .HDR_BYTES    (HDR_BYTES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_command        (in_command),
    .in_req_size       (in_req_size),
    .in_release_offset (in_release_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_data_offset   (out_data_offset),
    .out_free_bytes    (out_free_bytes),
    .cmd               (cmd),
    .st                (st)
  );

endmodule

`default_nettype wire
